/* rtl/core/ssm_pkg.sv */
`default_nettype none
package ssm_pkg;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int NORM_W       = 62;
    localparam int ROOT_W       = 31;
    localparam int SCALE_W      = 46;
    localparam int CX_W         = 34;
    localparam int CZ_W         = 26;
    localparam int SHIFT_W      = 5;
    localparam int CORDIC_STEPS = 23;
    localparam int ROW_W        = 12;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HSCALE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLAT_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEEP_LIMIT = 3'd4;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [1:0] CLS_FLAT   = 2'd0;
    localparam logic [1:0] CLS_NORMAL = 2'd1;
    localparam logic [1:0] CLS_STEEP  = 2'd2;

    localparam logic [13:0] SLOPE_MAX = 14'd11520;

    localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
        22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2, 22'd1
    };

    typedef struct packed {
        logic        cmd;
        logic [15:0] height;
    } t_in_word;

    typedef struct packed {
        logic [13:0] slope_deg;
        logic [1:0]  slope_class;
        logic        frame_last;
    } t_out_word;

    typedef struct packed {
        logic vld;
        logic last;
    } t_tag;

    typedef struct packed {
        logic               vld;
        logic               last;
        logic               zero;
        logic [SHIFT_W-1:0] s;
    } t_meta;

    function automatic logic signed [CX_W-1:0] shr_tz(input logic signed [CX_W-1:0] v,
                                                      input int n);
        logic signed [CX_W-1:0] a;
        if (v < 0) begin
            a = -v;
            return -(a >>> n);
        end
        return v >>> n;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/ssm_front.sv */
`default_nettype none
module ssm_front #(
    parameter int MAX_WIDTH   = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_adv,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  ssm_pkg::t_in_word             i_in_data,
    input  wire  [10:0]                   i_row_width,
    input  wire  [12:0]                   i_frame_rows,
    output ssm_pkg::t_tag                 o_tag,
    output logic signed [HEIGHT_BITS+2:0] o_gx,
    output logic signed [HEIGHT_BITS+2:0] o_gy
);
    import ssm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int GW = HEIGHT_BITS + 3;

    logic [HEIGHT_BITS-1:0] upper_mem  [MAX_WIDTH];
    logic [HEIGHT_BITS-1:0] middle_mem [MAX_WIDTH];

    logic [CW-1:0]          r_col, n_col;
    logic [ROW_W-1:0]       r_row, n_row;
    logic                   r_drain, n_drain;
    logic                   r_pend, n_pend;
    logic                   r_pend_last, n_pend_last;
    logic [HEIGHT_BITS-1:0] r_win [3][3];
    logic [HEIGHT_BITS-1:0] r_rd_up, r_rd_mid;
    t_tag                   r_e, r_g;
    logic signed [GW-1:0]   r_gx, r_gy;

    logic                   acc, at_end, row_last;
    logic [13:0]            wc, last_col;
    logic [12:0]            hc, last_row;
    logic [HEIGHT_BITS-1:0] hv, wr_up, wr_mid, p_t, p_m, p_b;
    logic                   we, push, first, emit, emit_last;
    logic signed [GW-1:0]   wv [3][3];
    logic signed [GW-1:0]   gx_c, gy_c;

    assign o_in_ready = i_adv && !r_pend;
    assign acc        = i_in_valid && o_in_ready;
    assign hv         = HEIGHT_BITS'(i_in_data.height);

    always_comb begin
        wc = 14'(i_row_width);
        if (wc < 14'd2) begin
            wc = 14'd2;
        end else if (wc > 14'(MAX_WIDTH)) begin
            wc = 14'(MAX_WIDTH);
        end
        last_col = wc - 14'd1;
        hc = i_frame_rows;
        if (hc < 13'd2) begin
            hc = 13'd2;
        end else if (hc > 13'd4096) begin
            hc = 13'd4096;
        end
        last_row = hc - 13'd1;
        at_end   = 14'(r_col) >= last_col;
        row_last = 13'(r_row) >= last_row;
    end

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_drain     = r_drain;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        we          = 1'b0;
        wr_up       = hv;
        wr_mid      = hv;
        push        = 1'b0;
        first       = 1'b0;
        p_t         = hv;
        p_m         = hv;
        p_b         = hv;
        emit        = 1'b0;
        emit_last   = 1'b0;
        if (i_adv && r_pend) begin
            push      = 1'b1;
            p_t       = r_win[2][0];
            p_m       = r_win[2][1];
            p_b       = r_win[2][2];
            emit      = 1'b1;
            emit_last = r_pend_last;
            n_pend    = 1'b0;
        end else if (acc) begin
            if (r_drain) begin
                if (i_in_data.cmd == CMD_FLUSH) begin
                    push  = 1'b1;
                    first = (r_col == '0);
                    p_t   = r_rd_up;
                    p_m   = r_rd_mid;
                    p_b   = r_rd_mid;
                    emit  = (r_col != '0);
                    if (at_end) begin
                        n_pend      = 1'b1;
                        n_pend_last = 1'b1;
                        n_drain     = 1'b0;
                        n_row       = '0;
                        n_col       = '0;
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end else if (i_in_data.cmd == CMD_PIXEL) begin
                push  = 1'b1;
                first = (r_col == '0);
                we    = 1'b1;
                if (r_row != '0) begin
                    wr_up = r_rd_mid;
                    p_t   = r_rd_up;
                    p_m   = r_rd_mid;
                    emit  = (r_col != '0);
                end
                if (at_end) begin
                    n_pend      = (r_row != '0);
                    n_pend_last = 1'b0;
                    n_col       = '0;
                    if (row_last) begin
                        n_drain = 1'b1;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                wv[c][r] = $signed(GW'(r_win[c][r]));
            end
        end
        gx_c = (wv[2][0] + (wv[2][1] <<< 1) + wv[2][2])
             - (wv[0][0] + (wv[0][1] <<< 1) + wv[0][2]);
        gy_c = (wv[0][2] + (wv[1][2] <<< 1) + wv[2][2])
             - (wv[0][0] + (wv[1][0] <<< 1) + wv[2][0]);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            upper_mem[r_col]  <= wr_up;
            middle_mem[r_col] <= wr_mid;
        end
        r_rd_up  <= upper_mem[n_col];
        r_rd_mid <= middle_mem[n_col];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (first) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[c][0] <= p_t;
                    r_win[c][1] <= p_m;
                    r_win[c][2] <= p_b;
                end
            end else begin
                r_win[0]    <= r_win[1];
                r_win[1]    <= r_win[2];
                r_win[2][0] <= p_t;
                r_win[2][1] <= p_m;
                r_win[2][2] <= p_b;
            end
        end
        if (i_adv) begin
            r_gx <= gx_c;
            r_gy <= gy_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_drain     <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_e         <= '0;
            r_g         <= '0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_drain     <= n_drain;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            if (i_adv) begin
                r_e <= '{vld: emit, last: emit_last};
                r_g <= r_e;
            end
        end
    end

    assign o_tag = r_g;
    assign o_gx  = r_gx;
    assign o_gy  = r_gy;

endmodule
`default_nettype wire

/* rtl/core/ssm_sqrt_cell.sv */
`default_nettype none
module ssm_sqrt_cell #(
    parameter int STEP = 30
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  ssm_pkg::t_meta                i_meta,
    input  wire  [ssm_pkg::NORM_W-1:0]    i_rem,
    input  wire  [ssm_pkg::ROOT_W-1:0]    i_root,
    input  wire  [ssm_pkg::NORM_W-1:0]    i_val,
    output ssm_pkg::t_meta                o_meta,
    output logic [ssm_pkg::NORM_W-1:0]    o_rem,
    output logic [ssm_pkg::ROOT_W-1:0]    o_root,
    output logic [ssm_pkg::NORM_W-1:0]    o_val
);
    import ssm_pkg::*;

    logic [NORM_W:0]   trial;
    logic              take;
    t_meta             r_meta;
    logic [NORM_W-1:0] r_rem, r_val;
    logic [ROOT_W-1:0] r_root;

    assign trial = ((NORM_W+1)'(i_root) << (STEP + 1)) + ((NORM_W+1)'(1) << (2 * STEP));
    assign take  = (NORM_W+1)'(i_rem) >= trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= take ? NORM_W'((NORM_W+1)'(i_rem) - trial) : i_rem;
            r_root <= take ? (i_root | (ROOT_W'(1) << STEP)) : i_root;
            r_val  <= i_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta <= '0;
        end else if (i_en) begin
            r_meta <= i_meta;
        end
    end

    assign o_meta = r_meta;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_val  = r_val;

endmodule
`default_nettype wire

/* rtl/core/ssm_cordic_cell.sv */
`default_nettype none
module ssm_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  ssm_pkg::t_meta                       i_meta,
    input  wire  signed [ssm_pkg::CX_W-1:0]      i_x,
    input  wire  signed [ssm_pkg::CX_W-1:0]      i_y,
    input  wire  signed [ssm_pkg::CZ_W-1:0]      i_z,
    output ssm_pkg::t_meta                       o_meta,
    output logic signed [ssm_pkg::CX_W-1:0]      o_x,
    output logic signed [ssm_pkg::CX_W-1:0]      o_y,
    output logic signed [ssm_pkg::CZ_W-1:0]      o_z
);
    import ssm_pkg::*;

    logic signed [CX_W-1:0] xs, ys;
    logic signed [CZ_W-1:0] ang;
    t_meta                  r_meta;
    logic signed [CX_W-1:0] r_x, r_y;
    logic signed [CZ_W-1:0] r_z;

    assign xs  = shr_tz(i_x, STEP);
    assign ys  = shr_tz(i_y, STEP);
    assign ang = $signed({4'b0000, ATAN_TAB[STEP]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[CX_W-1]) begin
                r_x <= i_x + ys;
                r_y <= i_y - xs;
                r_z <= i_z + ang;
            end else begin
                r_x <= i_x - ys;
                r_y <= i_y + xs;
                r_z <= i_z - ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta <= '0;
        end else if (i_en) begin
            r_meta <= i_meta;
        end
    end

    assign o_meta = r_meta;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule
`default_nettype wire

/* rtl/core/sobel_slope_map.sv */
// Slope map of a raster heightmap, 3x3 Sobel gradient magnitude.
// Input channel: one word per cycle, valid/ready. A word carries cmd and a
// height; pixels arrive in row order, one frame of frame_rows rows of
// row_width pixels. After the last row, one flush word per column drains
// the final row. Words that do not fit the current phase are taken and
// dropped. Output channel: slope_deg (degrees, 7 fraction bits), a
// flat/normal/steep class and frame_last on the frame's final result.
// Results of a row are produced while the next row streams in.
// Throughput: one input word per cycle while the receiver does not stall;
// the last word of each row after the first (and of the drain) produces two
// results; input ready drops while the second goes through the window alone.
// A result passes, after the word that causes it, through the chain of
// cells: window, gradient, square, sum, 5 normalize, 31 square root,
// scale load, 5 rescale, 23 CORDIC stages and the output register.
// When the receiver stalls, the whole chain holds and input ready drops.
// Reset (synchronous, active low) clears the counters and valid flags and
// loads the register defaults; the line stores need no clearing.
// Configuration: i_cfg_we writes register i_cfg_idx at once; write only
// while the block is empty.
`default_nettype none
module sobel_slope_map #(
    parameter int MAX_WIDTH   = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  ssm_pkg::t_in_word                    i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output ssm_pkg::t_out_word                   o_out_data,
    input  wire                                  i_cfg_we,
    input  wire  [ssm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [ssm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ssm_pkg::*;

    localparam int GW  = HEIGHT_BITS + 3;
    localparam int MW  = HEIGHT_BITS + 2;
    localparam int NST = 5;

    logic [10:0] r_row_width;
    logic [12:0] r_frame_rows;
    logic [15:0] r_hscale;
    logic [13:0] r_flat, r_steep;

    logic adv;

    t_tag                 f_tag;
    logic signed [GW-1:0] f_gx, f_gy;

    t_tag              r_sq_tag;
    logic [2*MW-1:0]   r_sqx, r_sqy;

    logic [NORM_W-1:0] r_nv [NST+1];
    t_meta             r_nm [NST+1];

    t_meta             sq_meta [ROOT_W+1];
    logic [NORM_W-1:0] sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root [ROOT_W+1];
    logic [NORM_W-1:0] sq_val  [ROOT_W+1];

    logic [SCALE_W-1:0] r_sx [NST+1];
    logic [SCALE_W-1:0] r_sy [NST+1];
    t_meta              r_sm [NST+1];

    t_meta                  cd_meta [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cd_x    [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cd_y    [CORDIC_STEPS+1];
    logic signed [CZ_W-1:0] cd_z    [CORDIC_STEPS+1];

    logic               r_out_valid;
    t_out_word          r_out_data;

    logic [MW-1:0]      ax, ay;
    logic [15:0]        h_eff;
    logic [CZ_W-1:0]    zc;
    logic [CZ_W-1:0]    zq;
    logic [13:0]        slope;
    logic [1:0]         cls;

    assign adv = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width  <= 11'd1024;
            r_frame_rows <= 13'd1024;
            r_hscale     <= 16'd256;
            r_flat       <= 14'd640;
            r_steep      <= 14'd5760;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_WIDTH:   r_row_width  <= i_cfg_data[10:0];
                REG_FRAME_ROWS:  r_frame_rows <= i_cfg_data[12:0];
                REG_HSCALE:      r_hscale     <= i_cfg_data;
                REG_FLAT_LIMIT:  r_flat       <= i_cfg_data[13:0];
                REG_STEEP_LIMIT: r_steep      <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    ssm_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_row_width  (r_row_width),
        .i_frame_rows (r_frame_rows),
        .o_tag        (f_tag),
        .o_gx         (f_gx),
        .o_gy         (f_gy)
    );

    assign ax = MW'(f_gx < 0 ? -f_gx : f_gx);
    assign ay = MW'(f_gy < 0 ? -f_gy : f_gy);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sqx    <= ax * ax;
            r_sqy    <= ay * ay;
            r_nv[0]  <= NORM_W'(r_sqx) + NORM_W'(r_sqy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_tag <= '0;
            r_nm[0]  <= '0;
        end else if (adv) begin
            r_sq_tag <= f_tag;
            r_nm[0]  <= '{vld: r_sq_tag.vld, last: r_sq_tag.last,
                          zero: (r_sqx == '0) && (r_sqy == '0), s: '0};
        end
    end

    for (genvar j = 0; j < NST; j++) begin : g_norm
        localparam int K = 16 >> j;
        logic sh;
        assign sh = (r_nv[j] >> (NORM_W - 2 * K)) == '0;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_nv[j+1] <= sh ? (r_nv[j] << (2 * K)) : r_nv[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nm[j+1] <= '0;
            end else if (adv) begin
                r_nm[j+1] <= '{vld: r_nm[j].vld, last: r_nm[j].last, zero: r_nm[j].zero,
                               s: r_nm[j].s + (sh ? SHIFT_W'(K) : SHIFT_W'(0))};
            end
        end
    end

    assign sq_meta[0] = r_nm[NST];
    assign sq_rem[0]  = r_nv[NST];
    assign sq_root[0] = '0;
    assign sq_val[0]  = r_nv[NST];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        ssm_sqrt_cell #(
            .STEP (ROOT_W - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_meta  (sq_meta[j]),
            .i_rem   (sq_rem[j]),
            .i_root  (sq_root[j]),
            .i_val   (sq_val[j]),
            .o_meta  (sq_meta[j+1]),
            .o_rem   (sq_rem[j+1]),
            .o_root  (sq_root[j+1]),
            .o_val   (sq_val[j+1])
        );
    end

    assign h_eff = (r_hscale == '0) ? 16'd1 : r_hscale;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sx[0] <= SCALE_W'(h_eff) << sq_meta[ROOT_W].s;
            r_sy[0] <= SCALE_W'(sq_root[ROOT_W]) << 5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm[0] <= '0;
        end else if (adv) begin
            r_sm[0] <= '{vld: sq_meta[ROOT_W].vld, last: sq_meta[ROOT_W].last,
                         zero: sq_meta[ROOT_W].zero || (sq_val[ROOT_W] == '0),
                         s: sq_meta[ROOT_W].s};
        end
    end

    for (genvar j = 0; j < NST; j++) begin : g_scale
        localparam int K = 16 >> j;
        logic [SCALE_W-1:0] w;
        logic               sh;
        assign w  = r_sx[j] | r_sy[j];
        assign sh = (w >> (K + 29)) != '0;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sx[j+1] <= sh ? (r_sx[j] >> K) : r_sx[j];
                r_sy[j+1] <= sh ? (r_sy[j] >> K) : r_sy[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sm[j+1] <= '0;
            end else if (adv) begin
                r_sm[j+1] <= r_sm[j];
            end
        end
    end

    assign cd_meta[0] = r_sm[NST];
    assign cd_x[0]    = $signed(CX_W'(r_sx[NST]));
    assign cd_y[0]    = $signed(CX_W'(r_sy[NST]));
    assign cd_z[0]    = '0;

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
        ssm_cordic_cell #(
            .STEP (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_meta  (cd_meta[j]),
            .i_x     (cd_x[j]),
            .i_y     (cd_y[j]),
            .i_z     (cd_z[j]),
            .o_meta  (cd_meta[j+1]),
            .o_x     (cd_x[j+1]),
            .o_y     (cd_y[j+1]),
            .o_z     (cd_z[j+1])
        );
    end

    always_comb begin
        zc = cd_z[CORDIC_STEPS][CZ_W-1] ? '0 : cd_z[CORDIC_STEPS];
        zq = (zc + CZ_W'(256)) >> 9;
        if (cd_meta[CORDIC_STEPS].zero) begin
            slope = '0;
        end else if (zq > CZ_W'(SLOPE_MAX)) begin
            slope = SLOPE_MAX;
        end else begin
            slope = zq[13:0];
        end
        if (slope < r_flat) begin
            cls = CLS_FLAT;
        end else if (slope > r_steep) begin
            cls = CLS_STEEP;
        end else begin
            cls = CLS_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= '{slope_deg: slope, slope_class: cls,
                            frame_last: cd_meta[CORDIC_STEPS].last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= cd_meta[CORDIC_STEPS].vld;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!r_out_valid || i_out_ready))
        else $error("input taken while output blocked");

    a_stall_holds_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(cd_meta[CORDIC_STEPS]))
        else $error("chain moved during stall");

    a_slope_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.slope_deg <= SLOPE_MAX))
        else $error("slope out of range");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.slope_class == CLS_FLAT ||
                         r_out_data.slope_class == CLS_NORMAL ||
                         r_out_data.slope_class == CLS_STEEP))
        else $error("bad class code");

endmodule
`default_nettype wire

/* tb/tb_sobel_slope_map.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_sobel_slope_map;
    import ssm_pkg::*;

    localparam int LINE_DEPTH = 1024;
    localparam int RANDOM_WORDS = 760;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_word i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_word o_out_data;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sobel_slope_map dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // slope predictor state
    logic [15:0] upper_row [LINE_DEPTH];
    logic [15:0] middle_row [LINE_DEPTH];
    logic [15:0] win [9];
    int unsigned col_cnt, row_cnt, drain_cnt;
    logic [10:0] cfg_width;
    logic [12:0] cfg_rows;
    logic [15:0] cfg_hscale;
    logic [13:0] cfg_flat, cfg_steep;

    t_out_word pending_slopes[$];
    t_out_word fresh_slopes[$];
    int errors = 0;

    function automatic longint shift_tz(input longint v, input int n);
        if (v < 0) return -((-v) >>> n);
        return v >>> n;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned rem, res, bitv;
        rem = v;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [13:0] slope_angle(input longint unsigned g2,
                                                input logic [15:0] hs);
        int s;
        longint unsigned sx, sy;
        longint x, y, z, xs, ys, q;
        longint unsigned h;
        if (g2 == 0) return 14'd0;
        h = (hs == 0) ? 64'd1 : 64'(hs);
        s = 0;
        while (g2 < (64'd1 << 60)) begin
            g2 = g2 << 2;
            s++;
        end
        sx = h << s;
        sy = root_floor(g2) << 5;
        while (sx >= (64'd1 << 30) || sy >= (64'd1 << 30)) begin
            sx = sx >> 1;
            sy = sy >> 1;
        end
        x = sx;
        y = sy;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            ys = shift_tz(y, i);
            xs = shift_tz(x, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
        end
        if (z < 0) z = 0;
        q = (z + 256) >>> 9;
        if (q > 11520) q = 11520;
        return q[13:0];
    endfunction

    function automatic void shift_window(input logic [15:0] t, input logic [15:0] m,
                                         input logic [15:0] b, input bit first);
        if (first) begin
            for (int c = 0; c < 3; c++) begin
                win[c*3] = t; win[c*3+1] = m; win[c*3+2] = b;
            end
        end else begin
            for (int k = 0; k < 6; k++) win[k] = win[k+3];
            win[6] = t; win[7] = m; win[8] = b;
        end
    endfunction

    function automatic void emit_slope(input bit last);
        longint gx, gy;
        t_out_word r;
        gx = (longint'(win[6]) + 2*longint'(win[7]) + longint'(win[8]))
           - (longint'(win[0]) + 2*longint'(win[1]) + longint'(win[2]));
        gy = (longint'(win[2]) + 2*longint'(win[5]) + longint'(win[8]))
           - (longint'(win[0]) + 2*longint'(win[3]) + longint'(win[6]));
        r.slope_deg = slope_angle(gx*gx + gy*gy, cfg_hscale);
        r.slope_class = (r.slope_deg < cfg_flat) ? CLS_FLAT :
                        (r.slope_deg > cfg_steep) ? CLS_STEEP : CLS_NORMAL;
        r.frame_last = last;
        fresh_slopes.push_back(r);
    endfunction

    function automatic int unsigned eff_width();
        return cfg_width < 2 ? 2 : (cfg_width > LINE_DEPTH ? LINE_DEPTH : cfg_width);
    endfunction

    function automatic int unsigned eff_rows();
        return cfg_rows < 2 ? 2 : (cfg_rows > 4096 ? 4096 : cfg_rows);
    endfunction

    function automatic void slope_reset();
        for (int k = 0; k < LINE_DEPTH; k++) begin
            upper_row[k] = '0; middle_row[k] = '0;
        end
        for (int k = 0; k < 9; k++) win[k] = '0;
        col_cnt = 0; row_cnt = 0; drain_cnt = 0;
        cfg_width = 11'd1024; cfg_rows = 13'd1024; cfg_hscale = 16'd256;
        cfg_flat = 14'd640; cfg_steep = 14'd5760;
    endfunction

    function automatic void slope_predict(input t_in_word w);
        int unsigned wd, hr, x;
        logic [15:0] t, m;
        wd = eff_width();
        hr = eff_rows();
        fresh_slopes.delete();
        if (drain_cnt != 0) begin
            if (w.cmd != CMD_FLUSH) return;
            x = drain_cnt - 1;
            if (x >= LINE_DEPTH) x = LINE_DEPTH - 1;
            shift_window(upper_row[x], middle_row[x], middle_row[x], x == 0);
            if (x >= 1) emit_slope(1'b0);
            if (x >= wd - 1) begin
                shift_window(win[6], win[7], win[8], 1'b0);
                emit_slope(1'b1);
                drain_cnt = 0; row_cnt = 0; col_cnt = 0;
            end else begin
                drain_cnt++;
            end
            return;
        end
        if (w.cmd != CMD_PIXEL) return;
        x = col_cnt;
        if (x >= LINE_DEPTH) x = LINE_DEPTH - 1;
        if (row_cnt == 0) begin
            upper_row[x] = w.height; middle_row[x] = w.height;
            shift_window(w.height, w.height, w.height, x == 0);
        end else begin
            t = upper_row[x]; m = middle_row[x];
            upper_row[x] = m; middle_row[x] = w.height;
            shift_window(t, m, w.height, x == 0);
            if (x >= 1) emit_slope(1'b0);
        end
        if (x >= wd - 1) begin
            if (row_cnt != 0) begin
                shift_window(win[6], win[7], win[8], 1'b0);
                emit_slope(1'b0);
            end
            col_cnt = 0;
            if (row_cnt >= hr - 1) drain_cnt = 1;
            else row_cnt = (row_cnt + 1) & 12'hFFF;
        end else begin
            col_cnt = x + 1;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_slopes.size() == 0) begin
                $error("unexpected result word %h", o_out_data);
                errors++;
            end else begin
                e = pending_slopes.pop_front();
                if (o_out_data.slope_deg !== e.slope_deg) begin
                    $error("slope_deg expected %0d actual %0d", e.slope_deg,
                           o_out_data.slope_deg);
                    errors++;
                end
                if (o_out_data.slope_class !== e.slope_class) begin
                    $error("slope_class expected %0d actual %0d", e.slope_class,
                           o_out_data.slope_class);
                    errors++;
                end
                if (o_out_data.frame_last !== e.frame_last) begin
                    $error("frame_last expected %0d actual %0d", e.frame_last,
                           o_out_data.frame_last);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            0: i_out_ready = 1'b1;
            1: i_out_ready = ($urandom_range(0, 3) != 0);
            2: i_out_ready = ($urandom_range(0, 1) != 0);
            default: i_out_ready = ($urandom_range(0, 19) == 0);
        endcase
    end

    int burst_left = 0;
    int real_words = 0;

    task automatic push_word(input t_in_word w, input bit typed, input int n_typed,
                             input t_out_word e0, input t_out_word e1);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_in_data = w;
        do @(posedge i_clk); while (!o_in_ready);
        slope_predict(w);
        if (drain_cnt != 0 || w.cmd == CMD_PIXEL) real_words++;
        if (typed) begin
            if (n_typed > 0) pending_slopes.push_back(e0);
            if (n_typed > 1) pending_slopes.push_back(e1);
        end else begin
            foreach (fresh_slopes[k]) pending_slopes.push_back(fresh_slopes[k]);
        end
    endtask

    task automatic send_word(input logic cmd, input logic [15:0] h);
        t_in_word w;
        w.cmd = cmd;
        w.height = h;
        push_word(w, 1'b0, 0, '0, '0);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_slopes.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        case (idx)
            REG_ROW_WIDTH: cfg_width = v[10:0];
            REG_FRAME_ROWS: cfg_rows = v[12:0];
            REG_HSCALE: cfg_hscale = v;
            REG_FLAT_LIMIT: cfg_flat = v[13:0];
            REG_STEEP_LIMIT: cfg_steep = v[13:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic setup(input logic [15:0] wd, input logic [15:0] rows, input logic [15:0] hs,
                         input logic [15:0] fl, input logic [15:0] st);
        write_reg(REG_ROW_WIDTH, wd);
        write_reg(REG_FRAME_ROWS, rows);
        write_reg(REG_HSCALE, hs);
        write_reg(REG_FLAT_LIMIT, fl);
        write_reg(REG_STEEP_LIMIT, st);
    endtask

    function automatic logic [15:0] pick_height(input int style, input int x, input int y,
                                                input logic [15:0] base);
        case (style)
            0: return 16'($urandom_range(0, 65535));
            1: return base + 16'(x * 37 + y * 11) + 16'($urandom_range(0, 7));
            2: return base;
            3: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: return base + 16'(x * 300) - 16'(y * 700) + 16'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_frame(input bit noisy, input bit hold_mid);
        int wd, hr, style;
        logic [15:0] base;
        wd = eff_width();
        hr = eff_rows();
        style = $urandom_range(0, 4);
        base = 16'($urandom_range(0, 65535));
        for (int y = 0; y < hr; y++) begin
            for (int x = 0; x < wd; x++) begin
                if (noisy && $urandom_range(0, 15) == 0)
                    send_word(CMD_FLUSH, 16'($urandom_range(0, 65535)));
                send_word(CMD_PIXEL, pick_height(style, x, y, base));
                if (hold_mid && y == hr - 1 && x == wd / 2) begin
                    @(negedge i_clk);
                    i_in_valid = 1'b0;
                    while (pending_slopes.size() != 0) @(posedge i_clk);
                    burst_left = 0;
                end
            end
        end
        for (int d = 0; d < wd; d++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_word(CMD_PIXEL, 16'($urandom_range(0, 65535)));
            send_word(CMD_FLUSH, 16'($urandom_range(0, 65535)));
        end
    endtask

    typedef struct {
        t_in_word  w;
        bit        typed;
        int        n;
        t_out_word e0;
        t_out_word e1;
    } t_stim_row;

    localparam t_out_word FLAT0 = '{slope_deg: 14'd0, slope_class: CLS_FLAT, frame_last: 1'b0};
    localparam t_out_word FLAT1 = '{slope_deg: 14'd0, slope_class: CLS_FLAT, frame_last: 1'b1};

    t_stim_row flat_frame [8] = '{
        '{'{CMD_FLUSH, 16'h1234}, 1'b1, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'h0000}, 1'b1, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'h0000}, 1'b1, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'h0000}, 1'b1, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'h0000}, 1'b1, 2, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'hFFFF}, 1'b1, 0, FLAT0, FLAT0},
        '{'{CMD_FLUSH, 16'h0000}, 1'b1, 0, FLAT0, FLAT0},
        '{'{CMD_FLUSH, 16'hFFFF}, 1'b1, 2, FLAT0, FLAT1}
    };

    t_stim_row edge_frame [12] = '{
        '{'{CMD_PIXEL, 16'h0000}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'hFFFF}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'h0000}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'hFFFF}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'h0000}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'hFFFF}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'h8000}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'h7FFF}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_PIXEL, 16'h0001}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_FLUSH, 16'h0000}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_FLUSH, 16'h0000}, 1'b0, 0, FLAT0, FLAT0},
        '{'{CMD_FLUSH, 16'h0000}, 1'b0, 0, FLAT0, FLAT0}
    };

    initial begin
        slope_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // all-flat 2x2 frame with stray words around it
        setup(16'd2, 16'd2, 16'd256, 16'd640, 16'd5760);
        foreach (flat_frame[k])
            push_word(flat_frame[k].w, flat_frame[k].typed, flat_frame[k].n,
                      flat_frame[k].e0, flat_frame[k].e1);
        wait_idle();

        // checkerboard extremes, steepest scale
        setup(16'd3, 16'd3, 16'd1, 16'd0, 16'd11520);
        foreach (edge_frame[k])
            push_word(edge_frame[k].w, 1'b0, 0, FLAT0, FLAT0);
        wait_idle();

        // clamped width and rows, widest and zero scale
        setup(16'd0, 16'd0, 16'hFFFF, 16'd11520, 16'd0);
        run_frame(1'b1, 1'b0);
        wait_idle();
        setup(16'd1, 16'd1, 16'd0, 16'd100, 16'd200);
        run_frame(1'b0, 1'b0);
        wait_idle();

        // wide row
        setup(16'd64, 16'd3, 16'd256, 16'd640, 16'd5760);
        run_frame(1'b0, 1'b0);
        wait_idle();

        real_words = 0;
        while (real_words < RANDOM_WORDS) begin
            logic [15:0] fl, st;
            fl = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(0, 11520));
            st = ($urandom_range(0, 5) == 0) ? 16'd11520 : 16'($urandom_range(fl, 11520));
            setup(16'($urandom_range(2, 14)), 16'($urandom_range(2, 7)),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                              : 16'($urandom_range(16, 2048)),
                  fl, st);
            run_frame($urandom_range(0, 3) == 0, real_words > 400 && real_words < 480);
            wait_idle();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sobel_slope_map.f */
rtl/core/ssm_pkg.sv
rtl/core/ssm_front.sv
rtl/core/ssm_sqrt_cell.sv
rtl/core/ssm_cordic_cell.sv
rtl/core/sobel_slope_map.sv
tb/tb_sobel_slope_map.sv
